### sv/sliding_window_message_throttle_top_defines.svh
// Assertion macros shared by the sliding window message throttle RTL.
// Depends on nothing; included by files that carry concurrent assertions.
`ifndef SLIDING_WINDOW_MESSAGE_THROTTLE_TOP_DEFINES_SVH
`define SLIDING_WINDOW_MESSAGE_THROTTLE_TOP_DEFINES_SVH

// Same-cycle implication, disabled during reset.
`define SWMT_ASSERT_NOW(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("swmt assertion failed");

// Next-cycle implication, disabled during reset.
`define SWMT_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("swmt assertion failed");

`endif

### sv/swmt_pkg.sv
// Shared constants, types and helpers for the sliding window message throttle.
// No dependencies; used by the interfaces, the ring memory and the top level.
package swmt_pkg;

  // Ring depth must be a power of two: slot arithmetic wraps naturally.
  localparam int RING_DEPTH = 64;
  localparam int SLOT_W     = $clog2(RING_DEPTH);
  localparam int FILL_W     = $clog2(RING_DEPTH + 1);

  localparam int TIME_W     = 32;
  localparam int WINDOW_W   = 20;
  localparam int MAXMSG_W   = 7;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 20;

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] REG_WINDOW = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_MAXMSG = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_MODE   = 2'd2;

  // Throttle modes
  localparam logic MODE_DELAY  = 1'b0;
  localparam logic MODE_REJECT = 1'b1;

  localparam logic [WINDOW_W-1:0] WINDOW_RESET = 20'd1000;
  localparam logic [MAXMSG_W-1:0] MAXMSG_RESET = 7'd8;

  typedef logic [SLOT_W-1:0] slot_t;
  typedef logic [FILL_W-1:0] fill_t;
  typedef logic [TIME_W-1:0] time_t;

  // Control from the top level to the ring memory
  typedef struct packed {
    logic  rd_en;
    slot_t rd_addr_a;
    slot_t rd_addr_b;
    logic  wr_en;
    slot_t wr_addr;
    time_t wr_data;
  } ring_req_t;

  // Limit in force: zero counts as one, anything above the ring as the ring depth.
  function automatic fill_t eff_limit(logic [MAXMSG_W-1:0] m);
    fill_t n;
    if (m == '0) begin
      n = fill_t'(1);
    end else if (int'(m) > RING_DEPTH) begin
      n = fill_t'(RING_DEPTH);
    end else begin
      n = fill_t'(m);
    end
    return n;
  endfunction

endpackage

### sv/swmt_if.sv
// Valid/ready channel interfaces: message input, throttle result, config write.
// Depends on swmt_pkg for field widths.
interface swmt_in_if;
  logic                        valid;
  logic                        ready;
  logic [swmt_pkg::TIME_W-1:0] arrival_ms;
  modport source (output valid, output arrival_ms, input ready);
  modport sink   (input valid, input arrival_ms, output ready);
endinterface

interface swmt_out_if;
  logic                          valid;
  logic                          ready;
  logic                          accepted;
  logic [swmt_pkg::WINDOW_W-1:0] wait_ms;
  modport source (output valid, output accepted, output wait_ms, input ready);
  modport sink   (input valid, input accepted, input wait_ms, output ready);
endinterface

interface swmt_cfg_if;
  logic                            valid;
  logic                            ready;
  logic [swmt_pkg::CFG_IDX_W-1:0]  index;
  logic [swmt_pkg::CFG_DATA_W-1:0] data;
  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

### sv/swmt_ring.sv
// Ring of accepted arrival times: one write port, two registered read ports.
// Depends on swmt_pkg for the ring request struct and widths.
module swmt_ring (
  input  logic                clk,
  input  swmt_pkg::ring_req_t req,
  output swmt_pkg::time_t     rd_data_a,
  output swmt_pkg::time_t     rd_data_b
);

  swmt_pkg::time_t mem [swmt_pkg::RING_DEPTH];

  // Write port
  always_ff @(posedge clk) begin
    if (req.wr_en) begin
      mem[req.wr_addr] <= req.wr_data;
    end
  end

  // Read ports; a write to the same slot in the same cycle is forwarded
  always_ff @(posedge clk) begin
    if (req.rd_en) begin
      rd_data_a <= (req.wr_en && (req.wr_addr == req.rd_addr_a)) ? req.wr_data
                                                                 : mem[req.rd_addr_a];
      rd_data_b <= (req.wr_en && (req.wr_addr == req.rd_addr_b)) ? req.wr_data
                                                                 : mem[req.rd_addr_b];
    end
  end

endmodule

### sv/sliding_window_message_throttle_top.sv
// Sliding window message throttle: top level, config registers and decision stage.
// Depends on swmt_pkg, the swmt interfaces, swmt_ring and the assertion header.
//
//   Channel  Dir  Beat fields               Notes
//   msg_in   in   arrival_ms[31:0]          one message arrival per beat
//   msg_out  out  accepted, wait_ms[19:0]   one result per message, in order
//   cfg      in   index[1:0], data[19:0]    register write, always ready
//
// One message per cycle unless the output stalls; result via s1 and output regs.
// The ring read for the next message is issued at both candidate slots so the
// decision of the message ahead never sits on the memory address path.
// Reset (rst, synchronous) clears slot pointer, fill count, pipeline valids and
// loads register defaults; ring contents are not cleared and need no sweep.
// A stalled output holds the decision stage; input stalls only when both are full.
`include "sliding_window_message_throttle_top_defines.svh"

module sliding_window_message_throttle_top (
  input  logic       clk,
  input  logic       rst,
  swmt_in_if.sink    msg_in,
  swmt_out_if.source msg_out,
  swmt_cfg_if.sink   cfg
);

  // Config registers
  logic [swmt_pkg::WINDOW_W-1:0] window;
  logic [swmt_pkg::MAXMSG_W-1:0] max_msg;
  logic                          mode;

  // Ring bookkeeping
  swmt_pkg::slot_t ws;
  swmt_pkg::fill_t fill;

  // Decision stage
  logic            s1_valid;
  swmt_pkg::time_t s1_now;
  logic            s1_sel;

  // Output register
  logic                          out_valid;
  logic                          out_acc;
  logic [swmt_pkg::WINDOW_W-1:0] out_wait;

  swmt_pkg::ring_req_t ring_req;
  swmt_pkg::time_t     rd_a;
  swmt_pkg::time_t     rd_b;
  swmt_pkg::fill_t     limit;
  swmt_pkg::time_t     prev_t;
  swmt_pkg::time_t     age;
  logic                not_full;
  logic                early;
  logic                hold;
  logic                s1_rec;
  logic                s1_acc;
  logic [swmt_pkg::WINDOW_W-1:0] s1_wait;
  logic                s1_adv;
  logic                in_fire;

  assign cfg.ready = 1'b1;

  // Register writes; unknown index ignored
  always_ff @(posedge clk) begin
    if (rst) begin
      window  <= swmt_pkg::WINDOW_RESET;
      max_msg <= swmt_pkg::MAXMSG_RESET;
      mode    <= swmt_pkg::MODE_DELAY;
    end else if (cfg.valid) begin
      unique case (cfg.index)
        swmt_pkg::REG_WINDOW: window  <= cfg.data[swmt_pkg::WINDOW_W-1:0];
        swmt_pkg::REG_MAXMSG: max_msg <= cfg.data[swmt_pkg::MAXMSG_W-1:0];
        swmt_pkg::REG_MODE:   mode    <= cfg.data[0];
        default: ;
      endcase
    end
  end

  assign limit = swmt_pkg::eff_limit(max_msg);

  // Handshakes
  assign s1_adv       = s1_valid && (!out_valid || msg_out.ready);
  assign msg_in.ready = !s1_valid || s1_adv;
  assign in_fire      = msg_in.valid && msg_in.ready;

  // Decision: compare age of the limit-th previous accepted arrival with the window
  always_comb begin
    prev_t   = s1_sel ? rd_b : rd_a;
    age      = s1_now - prev_t;
    not_full = fill < limit;
    early    = age < swmt_pkg::TIME_W'(window);
    hold     = !not_full && early;
    s1_rec   = !(hold && (mode == swmt_pkg::MODE_REJECT));
    s1_acc   = s1_rec;
    s1_wait  = (hold && (mode == swmt_pkg::MODE_DELAY)) ?
               (window - age[swmt_pkg::WINDOW_W-1:0]) : '0;
  end

  // Ring access: port a if the message ahead is not recorded, port b if it is
  always_comb begin
    ring_req.rd_en     = in_fire;
    ring_req.rd_addr_a = ws - limit[swmt_pkg::SLOT_W-1:0];
    ring_req.rd_addr_b = ws + swmt_pkg::slot_t'(1) - limit[swmt_pkg::SLOT_W-1:0];
    ring_req.wr_en     = s1_adv && s1_rec;
    ring_req.wr_addr   = ws;
    ring_req.wr_data   = s1_now;
  end

  swmt_ring u_ring (
    .clk       (clk),
    .req       (ring_req),
    .rd_data_a (rd_a),
    .rd_data_b (rd_b)
  );

  // Slot pointer and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      ws   <= '0;
      fill <= '0;
    end else if (ring_req.wr_en) begin
      ws <= ws + swmt_pkg::slot_t'(1);
      if (fill != swmt_pkg::fill_t'(swmt_pkg::RING_DEPTH)) begin
        fill <= fill + swmt_pkg::fill_t'(1);
      end
    end
  end

  // Decision stage registers
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_fire) begin
      s1_valid <= 1'b1;
    end else if (s1_adv) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_now <= msg_in.arrival_ms;
      s1_sel <= s1_adv && s1_rec;
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (s1_adv) begin
      out_valid <= 1'b1;
    end else if (msg_out.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv) begin
      out_acc  <= s1_acc;
      out_wait <= s1_wait;
    end
  end

  assign msg_out.valid    = out_valid;
  assign msg_out.accepted = out_acc;
  assign msg_out.wait_ms  = out_wait;

  // Checks
  `SWMT_ASSERT_NOW(a_fill_bound, clk, rst, 1'b1, fill <= swmt_pkg::fill_t'(swmt_pkg::RING_DEPTH))
  `SWMT_ASSERT_NOW(a_reject_no_wait, clk, rst, out_valid && !out_acc, out_wait == '0)
  `SWMT_ASSERT_NEXT(a_slot_advance, clk, rst, ring_req.wr_en, ws == $past(ws) + swmt_pkg::slot_t'(1))
  `SWMT_ASSERT_NOW(a_ready_when_empty, clk, rst, !s1_valid, msg_in.ready)
  `SWMT_ASSERT_NEXT(a_stall_holds, clk, rst, s1_valid && !s1_adv, s1_valid && $stable(s1_now))

endmodule

### bench/swmt_checker.sv
`timescale 1ns / 1ps
// Scoreboard for the sliding window message throttle: predicts each result beat
// from the observed message and register write beats and compares it field by field.
// Depends on swmt_pkg and the swmt channel interfaces.
module swmt_checker (
  input  logic clk,
  input  logic rst,
  swmt_in_if   msg_in,
  swmt_out_if  msg_out,
  swmt_cfg_if  cfg,
  output int   fail_count,
  output int   pending,
  output int   checked,
  output int   delayed,
  output int   rejected
);

  localparam int REPORT_MAX = 10;

  typedef struct packed {
    logic                          accepted;
    logic [swmt_pkg::WINDOW_W-1:0] wait_ms;
  } verdict_t;

  // Verdicts waiting for their result beat, oldest first
  verdict_t expected_q[$];

  // Own copy of the throttle state and registers
  swmt_pkg::time_t               arrival_log [swmt_pkg::RING_DEPTH];
  swmt_pkg::slot_t               next_slot;
  swmt_pkg::fill_t               logged;
  logic [swmt_pkg::WINDOW_W-1:0] window_len;
  logic [swmt_pkg::MAXMSG_W-1:0] msg_limit;
  logic                          mode_sel;

  int errors     = 0;
  int n_checked  = 0;
  int n_delayed  = 0;
  int n_rejected = 0;

  function automatic void log_arrival(swmt_pkg::time_t t);
    arrival_log[next_slot] = t;
    next_slot = next_slot + swmt_pkg::slot_t'(1);
    if (logged < swmt_pkg::fill_t'(swmt_pkg::RING_DEPTH)) logged = logged + swmt_pkg::fill_t'(1);
  endfunction

  // Decide one message and update the log of accepted arrivals
  function automatic verdict_t judge_arrival(swmt_pkg::time_t now);
    swmt_pkg::fill_t limit;
    swmt_pkg::slot_t old_slot;
    swmt_pkg::time_t age;
    verdict_t        v;
    // zero limit acts as one, anything past the ring as the ring depth
    limit = (msg_limit == '0) ? swmt_pkg::fill_t'(1) : swmt_pkg::fill_t'(msg_limit);
    if (limit > swmt_pkg::fill_t'(swmt_pkg::RING_DEPTH)) begin
      limit = swmt_pkg::fill_t'(swmt_pkg::RING_DEPTH);
    end
    v.accepted = 1'b1;
    v.wait_ms  = '0;
    if (logged < limit) begin
      log_arrival(now);
    end else begin
      old_slot = next_slot - swmt_pkg::slot_t'(limit);
      age = now - arrival_log[old_slot];
      if (age < swmt_pkg::time_t'(window_len)) begin
        if (mode_sel == swmt_pkg::MODE_DELAY) begin
          v.wait_ms = window_len - age[swmt_pkg::WINDOW_W-1:0];
          log_arrival(now);
        end else begin
          v.accepted = 1'b0;
        end
      end else begin
        log_arrival(now);
      end
    end
    return v;
  endfunction

  function automatic void note_mismatch(string field, logic [swmt_pkg::WINDOW_W-1:0] want,
                                        logic [swmt_pkg::WINDOW_W-1:0] got);
    errors++;
    if (errors <= REPORT_MAX)
      $display("Mismatch on result %0d, %s: expected %0d, got %0d",
               n_checked, field, want, got);
  endfunction

  always @(posedge clk) begin
    verdict_t want;
    if (rst) begin
      expected_q.delete();
      next_slot  = '0;
      logged     = '0;
      window_len = swmt_pkg::WINDOW_RESET;
      msg_limit  = swmt_pkg::MAXMSG_RESET;
      mode_sel   = swmt_pkg::MODE_DELAY;
    end else begin
      // result beat against the oldest expectation
      if (msg_out.valid && msg_out.ready) begin
        if (expected_q.size() == 0) begin
          errors++;
          if (errors <= REPORT_MAX)
            $display("Result beat with nothing expected: accepted=%0b wait_ms=%0d",
                     msg_out.accepted, msg_out.wait_ms);
        end else begin
          want = expected_q.pop_front();
          if (msg_out.accepted !== want.accepted)
            note_mismatch("accepted", {{(swmt_pkg::WINDOW_W-1){1'b0}}, want.accepted},
                          {{(swmt_pkg::WINDOW_W-1){1'b0}}, msg_out.accepted});
          if (msg_out.wait_ms !== want.wait_ms)
            note_mismatch("wait_ms", want.wait_ms, msg_out.wait_ms);
          n_checked++;
          if (!want.accepted) n_rejected++;
          else if (want.wait_ms != '0) n_delayed++;
        end
      end
      // register write beat
      if (cfg.valid && cfg.ready) begin
        case (cfg.index)
          swmt_pkg::REG_WINDOW: window_len = cfg.data[swmt_pkg::WINDOW_W-1:0];
          swmt_pkg::REG_MAXMSG: msg_limit  = cfg.data[swmt_pkg::MAXMSG_W-1:0];
          swmt_pkg::REG_MODE:   mode_sel   = cfg.data[0];
          default: ;
        endcase
      end
      // message beat
      if (msg_in.valid && msg_in.ready)
        expected_q.push_back(judge_arrival(msg_in.arrival_ms));
    end
    fail_count <= errors;
    pending    <= expected_q.size();
    checked    <= n_checked;
    delayed    <= n_delayed;
    rejected   <= n_rejected;
  end

endmodule

### bench/tb.sv
`timescale 1ns / 1ps
// Testbench top for the sliding window message throttle: clock, reset, stimulus
// through the message and register channels, output back-pressure and the verdict.
// Depends on swmt_pkg, the swmt interfaces, swmt_checker and the throttle RTL.
module tb;

  localparam int CYCLE_LIMIT = 200000;
  localparam int PHASES      = 12;
  localparam int PHASE_ITEMS = 110;
  localparam int HOLD_CYCLES = 300;
  localparam logic [swmt_pkg::CFG_IDX_W-1:0] REG_SPARE  = 2'd3;
  localparam logic [swmt_pkg::WINDOW_W-1:0]  WINDOW_MAX = '1;

  logic clk = 1'b0;
  logic rst;

  swmt_in_if  msg_in ();
  swmt_out_if msg_out ();
  swmt_cfg_if cfg ();

  int fail_count, pending, checked, delayed, rejected;
  int tx_idle_pct  = 0;
  int rx_stall_pct = 0;
  int hold_req     = 0;
  int cycle_count  = 0;
  int cfg_writes   = 0;
  int items_sent   = 0;
  swmt_pkg::time_t cur_t;

  always #2 clk = ~clk;

  sliding_window_message_throttle_top dut (
    .clk     (clk),
    .rst     (rst),
    .msg_in  (msg_in),
    .msg_out (msg_out),
    .cfg     (cfg)
  );

  swmt_checker chk (
    .clk        (clk),
    .rst        (rst),
    .msg_in     (msg_in),
    .msg_out    (msg_out),
    .cfg        (cfg),
    .fail_count (fail_count),
    .pending    (pending),
    .checked    (checked),
    .delayed    (delayed),
    .rejected   (rejected)
  );

  // Run limit
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles, %0d results still outstanding",
               cycle_count, pending);
      $display("*** FAILED ***");
      $finish;
    end
  end

  // Result side: random stalls, plus a long hold-off whenever one is requested
  initial begin
    int hold_left;
    int hold_seen;
    hold_left = 0;
    hold_seen = 0;
    msg_out.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_left == 0 && hold_seen != hold_req) begin
        hold_seen = hold_req;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        msg_out.ready <= 1'b0;
      end else begin
        msg_out.ready <= ($urandom_range(99) >= rx_stall_pct);
      end
    end
  end

  // Offer one message beat; valid stays high after acceptance for back-to-back beats
  task automatic send_msg(input swmt_pkg::time_t t);
    if (tx_idle_pct > 0 && $urandom_range(99) < tx_idle_pct) begin
      msg_in.valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < tx_idle_pct);
    end
    msg_in.valid      <= 1'b1;
    msg_in.arrival_ms <= t;
    do @(posedge clk); while (!msg_in.ready);
    items_sent++;
  endtask

  task automatic cfg_write(input logic [swmt_pkg::CFG_IDX_W-1:0] idx,
                           input logic [swmt_pkg::CFG_DATA_W-1:0] d);
    cfg.valid <= 1'b1;
    cfg.index <= idx;
    cfg.data  <= d;
    do @(posedge clk); while (!cfg.ready);
    cfg_writes++;
  endtask

  // Wait until every message has its result
  task automatic drain();
    @(posedge clk);
    while (pending != 0) @(posedge clk);
  endtask

  initial begin
    int unsigned                   r;
    int                            pace;
    int                            limit;
    logic [swmt_pkg::WINDOW_W-1:0] win;
    logic [swmt_pkg::MAXMSG_W-1:0] lim_reg;
    logic                          mode_bit;
    swmt_pkg::time_t               t;

    rst               <= 1'b1;
    msg_in.valid      <= 1'b0;
    msg_in.arrival_ms <= '0;
    cfg.valid         <= 1'b0;
    cfg.index         <= swmt_pkg::REG_WINDOW;
    cfg.data          <= '0;
    repeat (9) @(posedge clk);
    rst <= 1'b0;

    // Reset settings: fill up to the limit, one early message, a wrapped timestamp
    for (int i = 0; i < 8; i++) send_msg(swmt_pkg::time_t'(i));
    send_msg(32'd10);
    send_msg(32'hFFFF_FFFF);
    send_msg(32'd2000);
    msg_in.valid <= 1'b0;
    drain();

    // Reject mode, widest window, zero limit; high data bits must be dropped
    cfg_write(swmt_pkg::REG_MODE, {19'($urandom), swmt_pkg::MODE_REJECT});
    cfg_write(swmt_pkg::REG_WINDOW, WINDOW_MAX);
    cfg_write(swmt_pkg::REG_MAXMSG, 20'hFFF80);
    cfg.valid <= 1'b0;
    send_msg(32'd100);
    send_msg(32'd101);
    send_msg(32'd0);
    send_msg(32'd5);
    msg_in.valid <= 1'b0;
    drain();

    // Spare index ignored, limit past the ring, zero window, back to delay mode
    cfg_write(REG_SPARE, 20'hFFFFF);
    cfg_write(swmt_pkg::REG_MAXMSG, 20'h0007F);
    cfg_write(swmt_pkg::REG_WINDOW, '0);
    cfg_write(swmt_pkg::REG_MODE, 20'hFFFFE);
    cfg.valid <= 1'b0;
    for (int i = 0; i < 4; i++) send_msg(swmt_pkg::time_t'($urandom()));
    msg_in.valid <= 1'b0;
    drain();

    // Random phases, each with its own settings and idle pattern
    for (int p = 0; p < PHASES; p++) begin
      case (p % 4)
        0: begin tx_idle_pct = 0;  rx_stall_pct = 0;  end
        1: begin tx_idle_pct = 86; rx_stall_pct = 0;  end
        2: begin tx_idle_pct = 0;  rx_stall_pct = 86; end
        default: begin tx_idle_pct = 34; rx_stall_pct = 34; end
      endcase
      case (p % 6)
        0: win = '0;
        1: win = 20'd1;
        2: win = WINDOW_MAX;
        default: win = 20'($urandom_range(20, 3000));
      endcase
      case (p % 5)
        0: lim_reg = '0;
        1: lim_reg = 7'd1;
        2: lim_reg = 7'd64;
        3: lim_reg = 7'd127;
        default: lim_reg = 7'($urandom_range(2, 63));
      endcase
      mode_bit = ((p / 2) % 2 == 1) ? swmt_pkg::MODE_REJECT : swmt_pkg::MODE_DELAY;

      cfg_write(swmt_pkg::REG_WINDOW, win);
      cfg_write(swmt_pkg::REG_MAXMSG, {13'($urandom), lim_reg});
      cfg_write(swmt_pkg::REG_MODE, {19'($urandom), mode_bit});
      cfg.valid <= 1'b0;

      // spacing that keeps arrivals near the allowed rate
      limit = (lim_reg == '0) ? 1 : ((lim_reg > 7'd64) ? 64 : int'(lim_reg));
      pace  = int'(win) / limit;
      if ($urandom_range(3) == 0)
        cur_t = 32'hFFFF_FFFF - swmt_pkg::time_t'($urandom_range(0, 4 * pace + 100));
      else
        cur_t = swmt_pkg::time_t'($urandom());

      // long output hold-off while the sender keeps offering
      if (p % 4 == 0 && p > 0) hold_req++;

      for (int k = 0; k < PHASE_ITEMS; k++) begin
        r = $urandom_range(99);
        if (r < 8) begin
          t = swmt_pkg::time_t'($urandom());
        end else if (r < 13) begin
          t = cur_t - swmt_pkg::time_t'($urandom_range(1, 5000));
        end else begin
          if (r < 22) begin
            cur_t = cur_t + swmt_pkg::time_t'(win) + swmt_pkg::time_t'($urandom_range(0, 50));
          end else begin
            cur_t = cur_t + swmt_pkg::time_t'($urandom_range(0, 2 * pace + 1));
          end
          t = cur_t;
        end
        send_msg(t);
      end
      msg_in.valid <= 1'b0;
      drain();
    end

    repeat (8) @(posedge clk);
    $display("Run covered %0d messages over %0d setting phases with %0d register writes",
             items_sent, PHASES + 3, cfg_writes);
    $display("  %0d results checked: %0d held with a wait, %0d refused",
             checked, delayed, rejected);
    if (fail_count == 0 && pending == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
